[rtl/core/rckf_pkg.sv]
package rckf_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

	// Configuration register widths
	localparam int MODE_W     = 3;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Channel positions inside a packed pixel
	localparam int CH_ALPHA = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_PASS = 3'd0,
		MODE_GREY = 3'd1,
		MODE_LOW  = 3'd2,
		MODE_HIGH = 3'd3,
		MODE_BW   = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	// Pixel as stored: [0] red, [1] green, [2] blue, [3] alpha
	typedef logic [3:0][7:0] rgba_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
		logic       flush;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       frame_end;
	} pix_out_t;

	// Cross window around the centre pixel
	typedef struct packed {
		rgba_t up;
		rgba_t left;
		rgba_t centre;
		rgba_t right;
		rgba_t down;
	} win_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              border;
	} filt_ctl_t;

endpackage

[rtl/core/rckf_ram.sv]
module rckf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read ports; a read of the address being written returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/rckf_filter.sv]
module rckf_filter (
	input  rckf_pkg::win_t      win,
	input  rckf_pkg::filt_ctl_t ctl,
	output rckf_pkg::rgba_t     pix
);

	import rckf_pkg::*;

	logic [9:0]       sum3;
	logic [19:0]      grey_prod;
	logic [7:0]       grey;
	logic             dark;
	logic [2:0][9:0]  nsum;
	logic [2:0][7:0]  lp;
	logic [2:0][7:0]  hp;
	logic [2:0][10:0] nsum_rnd;
	logic [2:0][7:0]  quarter;
	logic [2:0][9:0]  diff;

	// Mean of the three colors: multiply by 683/2048, exact for sums up to 765
	always_comb begin
		sum3      = 10'(win.centre[0]) + 10'(win.centre[1]) + 10'(win.centre[2]);
		grey_prod = 20'(sum3) * 20'd683;
		grey      = grey_prod[18:11];
		dark      = (sum3 > 10'd383);
	end

	// Per-channel low pass and high pass from the cross taps
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nsum[k]     = 10'(win.up[k]) + 10'(win.left[k]) + 10'(win.right[k])
			            + 10'(win.down[k]);
			lp[k]       = {1'b0, nsum[k][9:3]} + {1'b0, win.centre[k][7:1]};
			nsum_rnd[k] = 11'(nsum[k]) + 11'd3;
			quarter[k]  = nsum_rnd[k][9:2];
			diff[k]     = {1'b0, win.centre[k], 1'b0} - {2'b00, quarter[k]};
			if (diff[k][9]) begin
				hp[k] = 8'd0;
			end else if (diff[k][8]) begin
				hp[k] = 8'hFF;
			end else begin
				hp[k] = diff[k][7:0];
			end
		end
	end

	// Select by mode; unknown modes and, outside grey mode, borders pass the centre
	always_comb begin
		pix = win.centre;
		case (ctl.mode)
			MODE_GREY: begin
				pix[2:0] = {grey, grey, grey};
			end
			MODE_LOW: begin
				if (!ctl.border) pix[2:0] = lp;
			end
			MODE_HIGH: begin
				if (!ctl.border) pix[2:0] = hp;
			end
			MODE_BW: begin
				if (!ctl.border) pix[2:0] = dark ? 24'h000000 : 24'hFFFFFF;
			end
			default: begin
			end
		endcase
		pix[CH_ALPHA] = win.centre[CH_ALPHA];
	end

endmodule

[rtl/core/rgba_cross_kernel_filter.sv]
// 3x3 cross-kernel RGBA filter. Pixels enter in raster order, one word per clock
// when neither side stalls; each result word is the pixel one row above the
// latest input, so results trail the input by one image row, and the last row
// of a frame is drained by flush words (or by the first row of the next frame).
// An accepted pixel goes from the line-store read registers to the result
// register: the line stores are read at the accepting edge, and the filter works
// between their read registers and the result register. The throughput is set by
// the single read port of each line-store copy, which is read once per word.
// The input stalls after reset and after every configuration write while the
// frame size products are refreshed. Line stores are not cleared; their
// contents before a row has been written only feed border pixels. Geometry writes
// restart the frame; configure only while the block is idle.
module rgba_cross_kernel_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  rckf_pkg::pix_in_t              pix_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output rckf_pkg::pix_out_t             res_data,
	input  logic                           cfg_wr_en,
	input  logic [rckf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rckf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import rckf_pkg::*;

	localparam int TOT_W = CNT_W + 1;

	// Configuration and derived geometry
	logic [MODE_W-1:0]   mode_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                settle_q;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [ROW_W-1:0]    h_m1;
	logic [TOT_W-1:0]    tot;
	logic [COL_W-1:0]    w_m1_q;
	logic [ROW_W-1:0]    h_m1_q;
	logic [CNT_W-1:0]    lrb_q;
	logic [CNT_W-1:0]    total_m1_q;

	// Position state
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             restart;

	// Accept stage
	logic             pix_acc;
	logic             is_flush;
	logic             fl_emit;
	logic [CNT_W-1:0] fl_off;
	logic             wrap_emit;
	logic             px_emit;
	logic             px_border;
	logic             emit;
	logic             load;
	logic             frame_end;
	logic [COL_W-1:0] rd_a_addr;
	logic [COL_W-1:0] rd_b_addr;
	logic             mid_we;
	rgba_t            pix_rgba;

	// Stage 1: line-store read data
	logic             valid_s1;
	logic             flush_s1;
	logic             emit_s1;
	logic             border_s1;
	logic             last_s1;
	logic             right_ok_s1;
	logic [COL_W-1:0] col_s1;
	rgba_t            down_s1;
	rgba_t            up_rd;
	rgba_t            mid_a_rd;
	rgba_t            mid_b_rd;
	rgba_t            left_q;
	logic             go_s1;
	logic             upper_we;

	// Stage 2: result register
	logic      valid_s2;
	pix_out_t  res_s2;
	win_t      win;
	filt_ctl_t fctl;
	rgba_t     filt_pix;

	// Clamp geometry to the supported range
	always_comb begin
		if (width_q < WIDTH_W'(3)) begin
			w_eff = WIDTH_W'(3);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q < HEIGHT_W'(3)) begin
			h_eff = HEIGHT_W'(3);
		end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		h_m1 = ROW_W'(h_eff - HEIGHT_W'(1));
		tot  = TOT_W'(h_eff) * TOT_W'(w_eff);
	end

	// Refresh derived geometry every cycle
	always_ff @(posedge clk) begin
		w_m1_q     <= COL_W'(w_eff - WIDTH_W'(1));
		h_m1_q     <= h_m1;
		lrb_q      <= CNT_W'(h_m1) * CNT_W'(w_eff);
		total_m1_q <= CNT_W'(tot - TOT_W'(1));
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PASS;
			width_q  <= WIDTH_W'(RESET_WIDTH);
			height_q <= HEIGHT_W'(RESET_HEIGHT);
			settle_q <= 1'b1;
		end else begin
			settle_q <= cfg_wr_en;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_MODE:   mode_q   <= cfg_wdata[MODE_W-1:0];
					REG_WIDTH:  width_q  <= cfg_wdata[WIDTH_W-1:0];
					REG_HEIGHT: height_q <= cfg_wdata[HEIGHT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign restart = cfg_wr_en && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

	// Decide whether this word emits and what it reads
	always_comb begin
		pix_acc   = pix_valid && !pix_stall;
		is_flush  = pix_data.flush;
		fl_emit   = (in_row_q == '0) && (out_cnt_q != '0) && (out_cnt_q >= lrb_q);
		fl_off    = out_cnt_q - lrb_q;
		wrap_emit = (in_row_q == '0) && (out_cnt_q != '0)
		          && (out_cnt_q == lrb_q + CNT_W'(in_col_q));
		px_emit   = (in_row_q != '0) || wrap_emit;
		px_border = (in_row_q == ROW_W'(1)) || wrap_emit || (in_col_q == '0)
		          || (in_col_q == w_m1_q);
		emit      = is_flush ? fl_emit : px_emit;
		load      = pix_acc && (!is_flush || fl_emit);
		frame_end = (out_cnt_q == total_m1_q);
		rd_a_addr = is_flush ? fl_off[COL_W-1:0] : in_col_q;
		rd_b_addr = in_col_q + COL_W'(1);
		mid_we    = pix_acc && !is_flush;
		pix_rgba  = {pix_data.alpha_in, pix_data.blue_in, pix_data.green_in,
		             pix_data.red_in};
	end

	// Advance input position and output count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_cnt_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_cnt_q <= '0;
		end else if (pix_acc) begin
			if (emit) begin
				out_cnt_q <= frame_end ? '0 : out_cnt_q + CNT_W'(1);
			end
			if (!is_flush) begin
				if (in_col_q == w_m1_q) begin
					in_col_q <= '0;
					in_row_q <= (in_row_q == h_m1_q) ? '0 : in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
		end
	end

	// Line stores: upper row, and two copies of the middle row for the centre
	// and right taps
	rckf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (upper_we),
		.waddr (col_s1),
		.wdata (mid_a_rd),
		.re    (load),
		.raddr (in_col_q),
		.rdata (up_rd)
	);

	rckf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_mid_a (
		.clk   (clk),
		.we    (mid_we),
		.waddr (in_col_q),
		.wdata (pix_rgba),
		.re    (load),
		.raddr (rd_a_addr),
		.rdata (mid_a_rd)
	);

	rckf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_mid_b (
		.clk   (clk),
		.we    (mid_we),
		.waddr (in_col_q),
		.wdata (pix_rgba),
		.re    (load),
		.raddr (rd_b_addr),
		.rdata (mid_b_rd)
	);

	// Stage 1 moves on unless its result has nowhere to go
	assign go_s1    = valid_s1 && (!emit_s1 || !valid_s2 || !res_stall);
	assign upper_we = go_s1 && !flush_s1;
	assign pix_stall = settle_q || (valid_s1 && !go_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold stage 1 payload
	always_ff @(posedge clk) begin
		if (load) begin
			flush_s1    <= is_flush;
			emit_s1     <= emit;
			border_s1   <= is_flush || px_border;
			last_s1     <= frame_end;
			right_ok_s1 <= (in_col_q != w_m1_q);
			col_s1      <= in_col_q;
			down_s1     <= pix_rgba;
		end
	end

	// Save the previous centre as the left tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (restart) begin
			left_q <= '0;
		end else if (go_s1 && !flush_s1) begin
			left_q <= mid_a_rd;
		end
	end

	// Filter the centre tap
	always_comb begin
		win.up     = up_rd;
		win.left   = left_q;
		win.centre = mid_a_rd;
		win.right  = right_ok_s1 ? mid_b_rd : '0;
		win.down   = down_s1;
		fctl.mode  = mode_q;
		fctl.border = border_s1;
	end

	rckf_filter u_filter (
		.win (win),
		.ctl (fctl),
		.pix (filt_pix)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && emit_s1) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit_s1) begin
			res_s2.red_out   <= filt_pix[0];
			res_s2.green_out <= filt_pix[1];
			res_s2.blue_out  <= filt_pix[2];
			res_s2.alpha_out <= filt_pix[CH_ALPHA];
			res_s2.frame_end <= last_s1;
		end
	end

	assign res_valid = valid_s2;
	assign res_data  = res_s2;

endmodule
